/* src/ksc_pkg.sv */
// Package for the keyword substitution cipher: function codes, character constants,
// state machine type, table access structs and the letter decode function.
// No dependencies.
package ksc_pkg;

    localparam int unsigned NUM_LETTERS = 26;

    localparam logic [1:0] FUNC_KEY = 2'd0;
    localparam logic [1:0] FUNC_ENC = 2'd1;
    localparam logic [1:0] FUNC_DEC = 2'd2;

    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_Z       = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [4:0] LETTER_COUNT = 5'd26;
    localparam logic [4:0] LAST_LETTER  = 5'd25;

    typedef enum logic [0:0] {
        ST_RUN,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } letter_t;

    // Write of one cipher position and its inverse entry.
    typedef struct packed {
        logic       en;
        logic [4:0] pos;
        logic [4:0] letter;
    } tbl_wr_t;

    // Lookup in the forward or the inverse table.
    typedef struct packed {
        logic       en;
        logic       inv;
        logic [4:0] addr;
    } tbl_rd_t;

    function automatic letter_t letter_decode(input logic [7:0] b);
        letter_t res;
        res.hit = 1'b0;
        res.idx = 5'd0;
        if (b >= CHAR_A && b <= CHAR_Z)
        begin
            res.hit = 1'b1;
            res.idx = 5'(b - CHAR_A);
        end
        else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)
        begin
            res.hit = 1'b1;
            res.idx = 5'(b - CHAR_LOWER_A);
        end
        return res;
    endfunction

endpackage

/* src/ksc_if.sv */
// Valid/ready channel interfaces for the cipher input and result words.
// No dependencies.
interface ksc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] in_byte;
    logic       keyword_last;

    modport source(output valid, output func, output in_byte, output keyword_last,
                   input ready);
    modport sink(input valid, input func, input in_byte, input keyword_last,
                 output ready);
endinterface

interface ksc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source(output valid, output out_byte, input ready);
    modport sink(input valid, input out_byte, output ready);
endinterface

/* src/ksc_table.sv */
// Forward and inverse cipher tables held in two 26-entry synchronous memories.
// Entries never written read as the identity mapping. Depends on ksc_pkg.
module ksc_table
(
    input  logic             clk,
    input  logic             rst_n,
    input  ksc_pkg::tbl_wr_t wr,
    input  ksc_pkg::tbl_rd_t rd,
    output logic [4:0]       rd_value
);

    logic [4:0] sub_mem [ksc_pkg::NUM_LETTERS];
    logic [4:0] inv_mem [ksc_pkg::NUM_LETTERS];

    logic [ksc_pkg::NUM_LETTERS-1:0] sub_vld_reg;
    logic [ksc_pkg::NUM_LETTERS-1:0] sub_vld_next;
    logic [ksc_pkg::NUM_LETTERS-1:0] inv_vld_reg;
    logic [ksc_pkg::NUM_LETTERS-1:0] inv_vld_next;

    logic [4:0] sub_q_reg;
    logic [4:0] inv_q_reg;
    logic       sub_hit_reg;
    logic       inv_hit_reg;
    logic       inv_sel_reg;
    logic [4:0] addr_reg;
    logic [4:0] pick;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            sub_mem[wr.pos]    <= wr.letter;
            inv_mem[wr.letter] <= wr.pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            sub_q_reg   <= sub_mem[rd.addr];
            inv_q_reg   <= inv_mem[rd.addr];
            sub_hit_reg <= sub_vld_reg[rd.addr];
            inv_hit_reg <= inv_vld_reg[rd.addr];
            inv_sel_reg <= rd.inv;
            addr_reg    <= rd.addr;
        end
    end

    always_comb
    begin
        sub_vld_next = sub_vld_reg;
        inv_vld_next = inv_vld_reg;
        if (wr.en)
        begin
            sub_vld_next[wr.pos]    = 1'b1;
            inv_vld_next[wr.letter] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_vld_reg <= '0;
            inv_vld_reg <= '0;
        end
        else
        begin
            sub_vld_reg <= sub_vld_next;
            inv_vld_reg <= inv_vld_next;
        end
    end

    always_comb
    begin
        if (inv_sel_reg)
            pick = inv_hit_reg ? inv_q_reg : addr_reg;
        else
            pick = sub_hit_reg ? sub_q_reg : addr_reg;
        rd_value = (pick >= ksc_pkg::LETTER_COUNT) ? 5'd0 : pick;
    end

endmodule

/* src/ksc_keygen.sv */
// Keyword sequencer: tracks used letters and the next cipher position, and walks
// the alphabet to fill unused letters after the last keyword word. Depends on ksc_pkg.
module ksc_keygen
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             key_accept,
    input  ksc_pkg::letter_t key_letter,
    input  logic             key_last,
    output logic             busy,
    output ksc_pkg::tbl_wr_t wr
);

    ksc_pkg::state_t state_reg;
    ksc_pkg::state_t state_next;

    logic [ksc_pkg::NUM_LETTERS-1:0] used_reg;
    logic [ksc_pkg::NUM_LETTERS-1:0] used_next;
    logic [4:0]                      fill_reg;
    logic [4:0]                      fill_next;
    logic                            building_reg;
    logic                            building_next;
    logic [4:0]                      scan_reg;
    logic [4:0]                      scan_next;

    logic [ksc_pkg::NUM_LETTERS-1:0] used_eff;
    logic [4:0]                      fill_eff;
    logic [4:0]                      cand;
    logic                            cand_ok;
    logic                            place;
    logic                            active;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ksc_pkg::ST_RUN:
            begin
                if (key_accept && key_last)
                    state_next = ksc_pkg::ST_FILL;
            end
            ksc_pkg::ST_FILL:
            begin
                if (scan_reg == ksc_pkg::LAST_LETTER)
                    state_next = ksc_pkg::ST_RUN;
            end
            default:
            begin
                state_next = ksc_pkg::ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        busy    = 1'b0;
        cand    = key_letter.idx;
        cand_ok = key_accept && key_letter.hit;
        active  = key_accept;
        unique case (state_reg)
            ksc_pkg::ST_RUN:
            begin
                busy = 1'b0;
            end
            ksc_pkg::ST_FILL:
            begin
                busy    = 1'b1;
                cand    = scan_reg;
                cand_ok = 1'b1;
                active  = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        used_eff = building_reg ? used_reg : '0;
        fill_eff = building_reg ? fill_reg : 5'd0;
        place    = cand_ok && (fill_eff < ksc_pkg::LETTER_COUNT) && !used_eff[cand];

        wr.en     = place;
        wr.pos    = fill_eff;
        wr.letter = cand;

        used_next     = used_reg;
        fill_next     = fill_reg;
        building_next = building_reg;
        scan_next     = scan_reg;
        if (active)
        begin
            used_next     = place ? (used_eff | (ksc_pkg::NUM_LETTERS'(1) << cand)) : used_eff;
            fill_next     = fill_eff + 5'(place);
            building_next = 1'b1;
        end
        if (state_reg == ksc_pkg::ST_RUN)
            scan_next = 5'd0;
        else
            scan_next = scan_reg + 5'd1;
        if (state_reg == ksc_pkg::ST_FILL && scan_reg == ksc_pkg::LAST_LETTER)
            building_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ksc_pkg::ST_RUN;
            used_reg     <= '0;
            fill_reg     <= 5'd0;
            building_reg <= 1'b0;
            scan_reg     <= 5'd0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            fill_reg     <= fill_next;
            building_reg <= building_next;
            scan_reg     <= scan_next;
        end
    end

endmodule

/* src/keyword_substitution_cipher.sv */
// Top level of the keyword substitution cipher: input handshake, lookup stage and
// output register around ksc_keygen and ksc_table. Depends on ksc_pkg and ksc_if.
//
//  channel | dir | payload                         | word
//  din     | in  | func, in_byte, keyword_last     | keyword, encrypt or decrypt byte
//  dout    | out | out_byte                        | one per encrypt or decrypt byte
//
// Encrypt and decrypt words are taken one per cycle while the lookup stage is free or
// advancing and no alphabet fill runs; each result passes the registered table read,
// then the output register. Keyword words are taken likewise; the word marked last starts
// an alphabet fill over all 26 letters, writing each unused letter, while din.ready is low.
// After reset the tables read as the identity mapping at once; there is no clearing pass.
// A stalled dout holds its word while one further word waits in the lookup stage.
module keyword_substitution_cipher
(
    input logic     clk,
    input logic     rst_n,
    ksc_in_if.sink  din,
    ksc_out_if.source dout
);

    ksc_pkg::letter_t din_letter;
    ksc_pkg::tbl_wr_t tbl_wr;
    ksc_pkg::tbl_rd_t tbl_rd;
    logic [4:0]       rd_value;
    logic             busy;
    logic             accept;
    logic             key_accept;
    logic             text_accept;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_letter_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_adv;
    logic [7:0] s1_result;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;

    assign din_letter  = ksc_pkg::letter_decode(din.in_byte);
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready   = !busy && (!s1_valid_reg || s1_adv);
    assign accept      = din.valid && din.ready;
    assign key_accept  = accept && (din.func == ksc_pkg::FUNC_KEY);
    assign text_accept = accept &&
                         (din.func == ksc_pkg::FUNC_ENC || din.func == ksc_pkg::FUNC_DEC);

    always_comb
    begin
        tbl_rd.en   = text_accept;
        tbl_rd.inv  = (din.func == ksc_pkg::FUNC_DEC);
        tbl_rd.addr = din_letter.hit ? din_letter.idx : 5'd0;
    end

    ksc_keygen u_keygen
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_accept (key_accept),
        .key_letter (din_letter),
        .key_last   (din.keyword_last),
        .busy       (busy),
        .wr         (tbl_wr)
    );

    ksc_table u_table
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd       (tbl_rd),
        .rd_value (rd_value)
    );

    assign s1_result = s1_letter_reg ? 8'(ksc_pkg::CHAR_A + {3'd0, rd_value}) : s1_byte_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (text_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (dout.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_accept)
        begin
            s1_letter_reg <= din_letter.hit;
            s1_byte_reg   <= din.in_byte;
        end
        if (s1_adv)
            out_byte_reg <= s1_result;
    end

    assign dout.valid    = out_valid_reg;
    assign dout.out_byte = out_byte_reg;

endmodule

/* src/ksc_checker.sv */
// Port-level checker for keyword_substitution_cipher, attached by bind.
// Depends on ksc_pkg and on the top level's port names.
module ksc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       din_valid,
    input logic       din_ready,
    input logic [1:0] din_func,
    input logic       din_keyword_last,
    input logic       dout_valid,
    input logic       dout_ready,
    input logic [7:0] dout_out_byte
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid && $stable(dout_out_byte))
        else $error("result word changed while stalled");

    // Letters always leave in upper case.
    a_upper: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid |-> !(dout_out_byte >= ksc_pkg::CHAR_LOWER_A &&
                         dout_out_byte <= ksc_pkg::CHAR_LOWER_Z))
        else $error("lower-case letter on output");

    // The last keyword word starts the alphabet fill, which blocks input.
    a_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
        din_valid && din_ready && din_func == ksc_pkg::FUNC_KEY && din_keyword_last
        |=> !din_ready ##1 !din_ready)
        else $error("input taken during alphabet fill");

endmodule

bind keyword_substitution_cipher ksc_checker u_ksc_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .din_valid        (din.valid),
    .din_ready        (din.ready),
    .din_func         (din.func),
    .din_keyword_last (din.keyword_last),
    .dout_valid       (dout.valid),
    .dout_ready       (dout.ready),
    .dout_out_byte    (dout.out_byte)
);

/* verif/tb_top.sv */
// Self-checking testbench for keyword_substitution_cipher: directed and random words
// through the valid/ready channels, checked against a scoreboard that tracks the cipher tables.
// Depends on ksc_pkg, ksc_if and the keyword_substitution_cipher RTL.
module tb_top;

    localparam logic [1:0] FUNC_IDLE = 2'd3;
    localparam int ITEM_TARGET = 1450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_START = 1500;
    localparam int HOLD_LEN = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] in_byte;
        logic       last;
    } cipher_word_t;

    class cipher_scoreboard;
        logic [4:0]  fwd_map[ksc_pkg::NUM_LETTERS];
        logic [4:0]  inv_map[ksc_pkg::NUM_LETTERS];
        logic [25:0] placed;
        int          next_pos;
        bit          key_open;
        logic [7:0]  pending_bytes[$];
        int          errors;
        int          checked;
        int          enc_words;
        int          dec_words;
        int          keys_done;
        int          idle_words;

        function new();
            for (int i = 0; i < ksc_pkg::NUM_LETTERS; i++)
            begin
                fwd_map[i] = 5'(i);
                inv_map[i] = 5'(i);
            end
            placed = '0;
            next_pos = 0;
            key_open = 1'b0;
        endfunction

        function int letter_of(logic [7:0] b);
            logic [7:0] u;
            u = b;
            if (u >= 8'h61 && u <= 8'h7A)
                u = u - 8'h20;
            if (u >= 8'h41 && u <= 8'h5A)
                return int'(u - 8'h41);
            return -1;
        endfunction

        function void place(int idx);
            if (idx < 0 || next_pos >= ksc_pkg::NUM_LETTERS || placed[idx])
                return;
            fwd_map[next_pos] = 5'(idx);
            inv_map[idx] = 5'(next_pos);
            placed[idx] = 1'b1;
            next_pos++;
        endfunction

        function void note_word(cipher_word_t w);
            int idx;
            logic [4:0] v;
            idx = letter_of(w.in_byte);
            if (w.func == ksc_pkg::FUNC_KEY)
            begin
                if (!key_open)
                begin
                    placed = '0;
                    next_pos = 0;
                    key_open = 1'b1;
                end
                place(idx);
                if (w.last)
                begin
                    for (int l = 0; l < ksc_pkg::NUM_LETTERS; l++)
                        place(l);
                    key_open = 1'b0;
                    keys_done++;
                end
            end
            else if (w.func == ksc_pkg::FUNC_ENC || w.func == ksc_pkg::FUNC_DEC)
            begin
                if (w.func == ksc_pkg::FUNC_ENC)
                    enc_words++;
                else
                    dec_words++;
                if (idx < 0)
                    pending_bytes.push_back(w.in_byte);
                else
                begin
                    v = (w.func == ksc_pkg::FUNC_ENC) ? fwd_map[idx] : inv_map[idx];
                    if (v >= ksc_pkg::LETTER_COUNT)
                        v = 5'd0;
                    pending_bytes.push_back(ksc_pkg::CHAR_A + 8'(v));
                end
            end
            else
                idle_words++;
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (pending_bytes.size() == 0)
            begin
                $error("out_byte with no word pending: actual %h", got);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("out_byte mismatch: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    ksc_in_if din();
    ksc_out_if dout();

    keyword_substitution_cipher dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .din(din),
        .dout(dout)
    );

    cipher_scoreboard sb = new();
    int burst_left = 0;
    int items_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_word(input logic [1:0] f, input logic [7:0] b, input logic l);
        int gap;
        cipher_word_t w;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                din.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        din.valid <= 1'b1;
        din.func <= f;
        din.in_byte <= b;
        din.keyword_last <= l;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        w.func = f;
        w.in_byte = b;
        w.last = l;
        sb.note_word(w);
        burst_left--;
        if (f != FUNC_IDLE)
            items_sent++;
    endtask

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? ksc_pkg::CHAR_A : ksc_pkg::CHAR_LOWER_A;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 9) < 8)
            return any_letter();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_text(input int count);
        for (int i = 0; i < count; i++)
            send_word($urandom_range(0, 1) ? ksc_pkg::FUNC_ENC : ksc_pkg::FUNC_DEC,
                      text_byte(), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_keyword(input int len, input bit mix_text);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = ($urandom_range(0, 19) < 17) ? any_letter() : 8'($urandom_range(0, 255));
            send_word(ksc_pkg::FUNC_KEY, b, i == len - 1);
            if (mix_text && i < len - 1 && $urandom_range(0, 1))
                send_text($urandom_range(1, 3));
        end
    endtask

    task automatic run_directed();
        cipher_word_t plan[$];
        plan = '{
            '{ksc_pkg::FUNC_ENC, "A", 1'b0}, '{ksc_pkg::FUNC_ENC, "z", 1'b1},
            '{ksc_pkg::FUNC_ENC, 8'h00, 1'b0}, '{ksc_pkg::FUNC_DEC, 8'hFF, 1'b0},
            '{ksc_pkg::FUNC_DEC, "m", 1'b0}, '{FUNC_IDLE, "Q", 1'b1},
            '{ksc_pkg::FUNC_KEY, "Z", 1'b0}, '{ksc_pkg::FUNC_KEY, "e", 1'b0},
            '{ksc_pkg::FUNC_KEY, "b", 1'b0}, '{ksc_pkg::FUNC_ENC, "C", 1'b0},
            '{ksc_pkg::FUNC_DEC, "z", 1'b0}, '{ksc_pkg::FUNC_KEY, "R", 1'b0},
            '{ksc_pkg::FUNC_KEY, "a", 1'b0}, '{ksc_pkg::FUNC_KEY, "z", 1'b0},
            '{ksc_pkg::FUNC_KEY, "!", 1'b1}, '{ksc_pkg::FUNC_ENC, "a", 1'b0},
            '{ksc_pkg::FUNC_ENC, "Z", 1'b0}, '{ksc_pkg::FUNC_DEC, "Z", 1'b0},
            '{ksc_pkg::FUNC_DEC, "a", 1'b0}, '{ksc_pkg::FUNC_ENC, "@", 1'b0},
            '{ksc_pkg::FUNC_DEC, "{", 1'b0}, '{ksc_pkg::FUNC_KEY, "1", 1'b1},
            '{ksc_pkg::FUNC_ENC, "Q", 1'b0}, '{ksc_pkg::FUNC_KEY, "q", 1'b1},
            '{ksc_pkg::FUNC_DEC, "A", 1'b0}
        };
        foreach (plan[i])
            send_word(plan[i].func, plan[i].in_byte, plan[i].last);
    endtask

    task automatic run_random();
        int pick;
        int len;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 8);
                send_keyword(len, 1'b0);
                send_text($urandom_range(4, 24));
            end
            else if (pick < 80)
                send_text($urandom_range(1, 16));
            else if (pick < 92)
                send_keyword($urandom_range(2, 8), 1'b1);
            else
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int cyc;
        int mode;
        int left;
        cyc = 0;
        left = 0;
        mode = 0;
        dout.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                dout.ready <= 1'b0;
            else
                case (mode)
                    0: dout.ready <= 1'b1;
                    1: dout.ready <= ($urandom_range(0, 9) < 7);
                    2: dout.ready <= ($urandom_range(0, 9) < 2);
                    default: dout.ready <= (cyc % 7) >= 3;
                endcase
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (dout.valid && dout.ready)
                sb.check_result(dout.out_byte);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((din.valid && din.ready) || (dout.valid && dout.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("keyword_substitution_cipher verification failed");
        $finish;
    end

    initial
    begin
        din.valid = 1'b0;
        din.func = ksc_pkg::FUNC_KEY;
        din.in_byte = 8'h00;
        din.keyword_last = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        din.valid <= 1'b0;
        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d encrypt and %0d decrypt words, %0d finished keywords",
                 sb.enc_words, sb.dec_words, sb.keys_done);
        $display("and %0d unused-selector words; %0d result words were checked.",
                 sb.idle_words, sb.checked);
        if (sb.errors == 0)
            $display("keyword_substitution_cipher verification clean");
        else
            $display("keyword_substitution_cipher verification failed");
        $finish;
    end
endmodule
